// ===== rtl/uart_tx_rx_ring_buffers_core_assert.svh =====
// Assertion macros for the UART ring buffer block.
// Used by the port checker; no other dependencies.
`ifndef UART_TX_RX_RING_BUFFERS_CORE_ASSERT_SVH
`define UART_TX_RX_RING_BUFFERS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UART_RB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("uart ring buffer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UART_RB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("uart ring buffer check failed");

`endif

// ===== rtl/uart_rb_pkg.sv =====
// Shared types and constants for the UART ring buffer block.
// No dependencies; imported by the core and its checker.
package uart_rb_pkg;

  localparam int DefTxDepth = 32;
  localparam int DefRxDepth = 32;

  localparam int ByteW  = 8;
  localparam int CountW = 5;
  localparam int ErrW   = 5;

  localparam logic [ByteW-1:0] CH_CR = 8'h0D;
  localparam logic [ByteW-1:0] CH_NL = 8'h0A;

  // Error word bit positions
  localparam int ErrOverflowBit = 3;
  localparam int ErrNoDataBit   = 4;

  typedef enum logic [2:0] {
    OP_LINE_RX  = 3'd0,
    OP_TX_READY = 3'd1,
    OP_WRITE    = 3'd2,
    OP_READ     = 3'd3,
    OP_DISCARD  = 3'd4
  } op_e;

  typedef enum logic [0:0] {
    CFG_TX_NL_TO_CR = 1'b0,
    CFG_RX_CR_TO_NL = 1'b1
  } cfg_idx_e;

endpackage

// ===== rtl/uart_tx_rx_ring_buffers_core.sv =====
// Top level of the UART transmit/receive ring buffer block.
// Each item passes through the input register and then the result register.
// One item per cycle unless the output stalls; an item updates at most one ring's pointers.
// The ring memories are single-write, single-read arrays with a registered read port.
// Reset: asynchronous active low; clears pointers, error word, ready enable and config.
// Ring contents are not cleared; only written slots are ever read.
module uart_tx_rx_ring_buffers_core #(
  parameter int TX_DEPTH = uart_rb_pkg::DefTxDepth,
  parameter int RX_DEPTH = uart_rb_pkg::DefRxDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      opcode_i,
  input  logic [uart_rb_pkg::ByteW-1:0]   byte_in_i,
  input  logic                            frame_error_i,
  input  logic                            line_overrun_i,
  input  logic                            parity_error_i,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_index_i,
  input  logic [0:0]                      cfg_data_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [uart_rb_pkg::ByteW-1:0]   byte_out_o,
  output logic                            byte_valid_o,
  output logic                            write_accepted_o,
  output logic [uart_rb_pkg::CountW-1:0]  rx_available_o,
  output logic                            tx_all_free_o,
  output logic                            ready_irq_enable_o,
  output logic [uart_rb_pkg::ErrW-1:0]    error_word_o
);
  import uart_rb_pkg::*;

  localparam int TxPw = $clog2(TX_DEPTH);
  localparam int RxPw = $clog2(RX_DEPTH);

  // Configuration registers
  logic cfg_nl_to_cr_q, cfg_cr_to_nl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_nl_to_cr_q <= 1'b0;
      cfg_cr_to_nl_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TX_NL_TO_CR: cfg_nl_to_cr_q <= cfg_data_i[0];
        CFG_RX_CR_TO_NL: cfg_cr_to_nl_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register stage
  logic             s1_valid_q;
  logic [2:0]       s1_op_q;
  logic [ByteW-1:0] s1_byte_q;
  logic [2:0]       s1_line_q;   // {parity, overrun, frame}
  logic             advance;

  // An item leaves the input register when the result register is free or draining.
  assign advance    = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_op_q   <= opcode_i;
      s1_byte_q <= byte_in_i;
      s1_line_q <= {parity_error_i, line_overrun_i, frame_error_i};
    end
  end

  // Ring state
  logic [TxPw-1:0] tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d;
  logic [RxPw-1:0] rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d;
  logic [ErrW-1:0] err_q, err_d;
  logic            rdy_q, rdy_d;

  logic [TxPw-1:0] tx_wnext, tx_rnext;
  logic [RxPw-1:0] rx_wnext, rx_rnext;

  // Advance a pointer with wrap at the ring depth
  assign tx_wnext = (tx_wp_q == TxPw'(TX_DEPTH - 1)) ? '0 : tx_wp_q + 1'b1;
  assign tx_rnext = (tx_rp_q == TxPw'(TX_DEPTH - 1)) ? '0 : tx_rp_q + 1'b1;
  assign rx_wnext = (rx_wp_q == RxPw'(RX_DEPTH - 1)) ? '0 : rx_wp_q + 1'b1;
  assign rx_rnext = (rx_rp_q == RxPw'(RX_DEPTH - 1)) ? '0 : rx_rp_q + 1'b1;

  logic             tx_we, rx_we, pop_tx, pop_rx, accepted;
  logic [ByteW-1:0] tx_wdata;

  always_comb begin
    tx_wp_d  = tx_wp_q;
    tx_rp_d  = tx_rp_q;
    rx_wp_d  = rx_wp_q;
    rx_rp_d  = rx_rp_q;
    err_d    = err_q;
    rdy_d    = rdy_q;
    tx_we    = 1'b0;
    rx_we    = 1'b0;
    pop_tx   = 1'b0;
    pop_rx   = 1'b0;
    accepted = 1'b0;
    // Store a written newline as a carriage return when enabled
    tx_wdata = (cfg_nl_to_cr_q && s1_byte_q == CH_NL) ? CH_CR : s1_byte_q;
    unique case (s1_op_q)
      OP_LINE_RX: begin
        // Replace the error word with this byte's line status; flag a full ring
        err_d = {1'b0, (rx_wnext == rx_rp_q), s1_line_q};
        if (rx_wnext != rx_rp_q) begin
          rx_wp_d = rx_wnext;
          rx_we   = 1'b1;
        end
      end
      OP_TX_READY: begin
        if (tx_wp_q != tx_rp_q) begin
          tx_rp_d = tx_rnext;
          pop_tx  = 1'b1;
        end else begin
          rdy_d = 1'b0;
        end
      end
      OP_WRITE: begin
        if (tx_wnext != tx_rp_q) begin
          tx_wp_d  = tx_wnext;
          tx_we    = 1'b1;
          rdy_d    = 1'b1;
          accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (rx_wp_q == rx_rp_q) begin
          err_d[ErrNoDataBit] = 1'b1;
        end else begin
          rx_rp_d = rx_rnext;
          pop_rx  = 1'b1;
        end
      end
      OP_DISCARD: begin
        tx_wp_d = tx_rp_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wp_q <= '0;
      tx_rp_q <= '0;
      rx_wp_q <= '0;
      rx_rp_q <= '0;
      err_q   <= '0;
      rdy_q   <= 1'b0;
    end else if (advance) begin
      tx_wp_q <= tx_wp_d;
      tx_rp_q <= tx_rp_d;
      rx_wp_q <= rx_wp_d;
      rx_rp_q <= rx_rp_d;
      err_q   <= err_d;
      rdy_q   <= rdy_d;
    end
  end

  // Ring memories, registered read
  logic [ByteW-1:0] tx_mem [TX_DEPTH];
  logic [ByteW-1:0] rx_mem [RX_DEPTH];
  logic [ByteW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (advance && tx_we) begin
      tx_mem[tx_wnext] <= tx_wdata;
    end
    if (advance && rx_we) begin
      rx_mem[rx_wnext] <= s1_byte_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && pop_tx) begin
      rd_q <= tx_mem[tx_rnext];
    end else if (advance && pop_rx) begin
      rd_q <= rx_mem[rx_rnext];
    end
  end

  // Receive fill level from the updated pointers
  logic [RxPw:0] rx_cnt;

  always_comb begin
    if (rx_wp_d >= rx_rp_d) begin
      rx_cnt = {1'b0, rx_wp_d} - {1'b0, rx_rp_d};
    end else begin
      rx_cnt = {1'b0, rx_wp_d} + (RxPw + 1)'(RX_DEPTH) - {1'b0, rx_rp_d};
    end
  end

  // Result register
  logic              out_valid_q, bvalid_q, acc_q, txfree_q, rdyo_q, cr2nl_q;
  logic [CountW-1:0] avail_q;
  logic [ErrW-1:0]   erro_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      bvalid_q <= pop_tx || pop_rx;
      acc_q    <= accepted;
      avail_q  <= CountW'(rx_cnt);
      txfree_q <= (tx_wp_d == tx_rp_d);
      rdyo_q   <= rdy_d;
      erro_q   <= err_d;
      // Return a read carriage return as newline when enabled
      cr2nl_q  <= pop_rx && cfg_cr_to_nl_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign byte_valid_o       = bvalid_q;
  assign byte_out_o         = !bvalid_q ? '0 : ((cr2nl_q && rd_q == CH_CR) ? CH_NL : rd_q);
  assign write_accepted_o   = acc_q;
  assign rx_available_o     = avail_q;
  assign tx_all_free_o      = txfree_q;
  assign ready_irq_enable_o = rdyo_q;
  assign error_word_o       = erro_q;

endmodule

// ===== rtl/uart_rb_checker.sv =====
// Port-level checker for the UART ring buffer core, bound to the top level.
// Depends on uart_rb_pkg and the assertion macro header.
`include "uart_tx_rx_ring_buffers_core_assert.svh"

module uart_rb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [uart_rb_pkg::ByteW-1:0]   byte_out_o,
  input logic                            byte_valid_o,
  input logic                            write_accepted_o,
  input logic                            tx_all_free_o,
  input logic                            ready_irq_enable_o
);
  import uart_rb_pkg::*;

  // A result never carries both a popped byte and an accepted write
  `UART_RB_ASSERT_NOW(a_pop_xor_write, clk_i, rst_ni, out_valid_o, !(byte_valid_o && write_accepted_o))

  // Byte field is zero unless a byte was popped
  `UART_RB_ASSERT_NOW(a_idle_byte_zero, clk_i, rst_ni, out_valid_o && !byte_valid_o, byte_out_o == '0)

  // An accepted write leaves the transmit ring non-empty with the ready enable set
  `UART_RB_ASSERT_NOW(a_write_fills_tx, clk_i, rst_ni, out_valid_o && write_accepted_o, !tx_all_free_o && ready_irq_enable_o)

  // A stalled result holds
  `UART_RB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(byte_out_o))

endmodule

bind uart_tx_rx_ring_buffers_core uart_rb_checker u_uart_rb_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .byte_out_o         (byte_out_o),
  .byte_valid_o       (byte_valid_o),
  .write_accepted_o   (write_accepted_o),
  .tx_all_free_o      (tx_all_free_o),
  .ready_irq_enable_o (ready_irq_enable_o)
);
